// ----- hw/rtl/lfmd_pkg.sv -----
// package for line follow motor drive: types, constants and helpers
package lfmd_pkg;

	localparam int ErrW = 13;
	localparam int DutyW = 11;

	typedef enum logic [2:0] {
		MODE_NORMAL = 3'd0,
		MODE_SHARP  = 3'd1,
		MODE_LOST   = 3'd2,
		MODE_SETTLE = 3'd3,
		MODE_SEARCH = 3'd4
	} drive_mode_t;

	typedef enum logic [2:0] {
		REG_LEFT_BASE  = 3'd0,
		REG_RIGHT_BASE = 3'd1,
		REG_FLOOR      = 3'd2,
		REG_CEILING    = 3'd3,
		REG_SHARP_THR  = 3'd4,
		REG_COOLDOWN   = 3'd5,
		REG_SETTLE     = 3'd6,
		REG_LOST_FLOOR = 3'd7
	} reg_index_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_DECIDE,
		ST_QUOT,
		ST_FINISH
	} seq_state_t;

	// divider start and result group
	typedef struct packed {
		logic              start;
		logic signed [13:0] dividend;
		logic        [4:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic signed [13:0] quotient;
	} div_rsp_t;

	typedef struct packed {
		logic [10:0] left_base;
		logic [10:0] right_base;
		logic [10:0] floor;
		logic [10:0] ceiling;
		logic [11:0] sharp_thr;
		logic [7:0]  cooldown;
		logic [7:0]  settle;
		logic [10:0] lost_floor;
	} cfg_t;

	function automatic logic signed [13:0] lim14(input logic signed [13:0] v,
			input logic signed [13:0] hi);
		logic signed [13:0] r;
		r = v;
		if (v < -hi) r = -hi;
		if (v > hi) r = hi;
		return r;
	endfunction

	function automatic logic [10:0] clamp_duty(input logic signed [13:0] t,
			input logic [10:0] flr, input logic [10:0] ceil, input logic use_floor);
		logic [10:0] r;
		r = t[10:0];
		if (t <= 14'sd0) r = '0;
		else if (use_floor && t < $signed({3'b000, flr})) r = flr;
		else if (t > $signed({3'b000, ceil})) r = ceil;
		return r;
	endfunction

endpackage

// ----- hw/rtl/line_follow_motor_drive_top.sv -----
// top level of line follow motor drive controller
//  channel | direction | signals
//  sample  | in        | in_valid, in_stall, sensor_mask
//  result  | out       | out_valid, out_stall, left_duty .. steer_correction
//  config  | in        | cfg_we, cfg_index, cfg_data
// an item is accepted in idle, then the sequencer steps through divide, decide, quotient and finish states:
// two passes through the shared divider, the first for the line error and the second for the correction
// the result is registered when the second divider pass completes and is shown in the finish state
// one item at a time; in_stall stays high while an item is at work or its result waits
// reset clears all control state and restores register defaults
module line_follow_motor_drive_top
	import lfmd_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [6:0]         sensor_mask,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [10:0]        left_duty,
	output logic [10:0]        right_duty,
	output logic [2:0]         drive_mode,
	output logic signed [12:0] line_error,
	output logic               line_seen,
	output logic signed [9:0]  steer_correction,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [11:0]        cfg_data
);

	cfg_t        cfg_q;
	seq_state_t  state_q, state_d;
	div_req_t    dreq;
	div_rsp_t    drsp;

	logic [6:0]  mask_q;
	logic signed [12:0] held_q;
	logic [15:0] lost_q;
	logic        ever_q;
	logic [1:0]  tsign_q;
	drive_mode_t mode_q;
	logic [7:0]  settle_q;
	logic [3:0]  crun_q;
	logic signed [8:0] damp_q;
	logic signed [12:0] prev_q;
	logic [1:0]  erun_q;
	logic [1:0]  brun_q;
	logic [7:0]  cool_q;

	logic signed [13:0] sum;
	logic [2:0]  cnt;
	logic        seen, s1, s4, s7;
	logic signed [12:0] err;
	logic [12:0] aerr;
	logic [1:0]  erun_n, brun_n;
	logic [7:0]  cool_n;
	logic        confirmed, blocked, lost, center;
	drive_mode_t mode_n;
	logic [4:0]  divisor;
	logic [3:0]  crun_n;
	logic        zone, cdamp, flip;
	logic [6:0]  boost;

	always_comb begin
		sum = '0;
		cnt = '0;
		for (int i = 0; i < 7; i++) begin
			if (mask_q[i]) begin
				sum = sum + 14'(signed'(i - 3) * 1000);
				cnt = cnt + 3'd1;
			end
		end
	end

	assign seen = cnt != 3'd0;
	assign s1 = mask_q[0];
	assign s4 = mask_q[3];
	assign s7 = mask_q[6];
	assign err = held_q;
	assign aerr = err[12] ? 13'(-err) : err;

	always_comb begin
		cool_n = (cool_q != 8'd0) ? cool_q - 8'd1 : cool_q;
		if (seen && (s1 || s7)) erun_n = (erun_q < 2'd2) ? erun_q + 2'd1 : erun_q;
		else erun_n = '0;
		if (seen && {1'b0, aerr} >= {1'b0, cfg_q.sharp_thr})
			brun_n = (brun_q < 2'd2) ? brun_q + 2'd1 : brun_q;
		else brun_n = '0;
		confirmed = erun_n == 2'd2 || brun_n == 2'd2;
		if (mode_q == MODE_SHARP && !confirmed) cool_n = cfg_q.cooldown;
		blocked = cool_n != 8'd0 && mode_q != MODE_SHARP;
		lost = !seen && ever_q && tsign_q != 2'd0 && (settle_q != 8'd0 || lost_q >= 16'd3);
		center = seen && s4 && !s1 && !s7 && aerr <= 13'd500;
		crun_n = center ? ((crun_q < 4'd8) ? crun_q + 4'd1 : crun_q) : 4'd0;
		if (lost) mode_n = MODE_LOST;
		else if (!seen) mode_n = MODE_SEARCH;
		else if (confirmed && !blocked) mode_n = MODE_SHARP;
		else if (settle_q != 8'd0) mode_n = MODE_SETTLE;
		else mode_n = MODE_NORMAL;
		case (mode_n)
			MODE_SHARP:  divisor = 5'd8;
			MODE_SETTLE: divisor = 5'd22;
			default:     divisor = 5'd20;
		endcase
		zone = !s1 && !s7 && aerr <= 13'd1000;
		cdamp = zone && s4 && aerr <= 13'd450;
		flip = (prev_q > 0 && err < 0) || (prev_q < 0 && err > 0);
		// boost grows by 15 every five lost samples, up to 90
		boost = (lost_q >= 16'd30) ? 7'd90 :
			(lost_q >= 16'd25) ? 7'd75 :
			(lost_q >= 16'd20) ? 7'd60 :
			(lost_q >= 16'd15) ? 7'd45 :
			(lost_q >= 16'd10) ? 7'd30 :
			(lost_q >= 16'd5) ? 7'd15 : 7'd0;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:   if (in_valid) state_d = ST_DIV;
			ST_DIV:    if (drsp.done) state_d = ST_DECIDE;
			ST_DECIDE: state_d = ST_QUOT;
			ST_QUOT:   if (drsp.done) state_d = ST_FINISH;
			ST_FINISH: if (!out_stall) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		dreq.start = 1'b0;
		dreq.dividend = sum;
		dreq.divisor = {2'b00, cnt};
		case (state_q)
			ST_DECIDE: begin
				dreq.start = 1'b1;
				dreq.dividend = 14'(err);
				dreq.divisor = divisor;
			end
			default: ;
		endcase
	end

	logic signed [13:0] corr;
	logic signed [13:0] tgt, lt, rt;
	logic signed [8:0]  damp_n;
	logic [10:0] ld, rd;
	logic [7:0]  tmag;
	logic [15:0] tprod;

	always_comb begin
		corr = '0;
		damp_n = damp_q;
		lt = '0;
		rt = '0;
		ld = '0;
		rd = '0;
		tgt = '0;
		tmag = '0;
		tprod = '0;
		case (mode_q)
			MODE_LOST: begin
				corr = (tsign_q == 2'b01) ? 14'sd225 + 14'(boost) : -14'sd225 - 14'(boost);
				corr = lim14(corr, 14'sd470);
				lt = $signed({3'b000, cfg_q.left_base}) - corr;
				rt = $signed({3'b000, cfg_q.right_base}) + corr;
				if (corr >= 0 && lt < $signed({3'b000, cfg_q.lost_floor}))
					lt = $signed({3'b000, cfg_q.lost_floor});
				else if (corr < 0 && rt < $signed({3'b000, cfg_q.lost_floor}))
					rt = $signed({3'b000, cfg_q.lost_floor});
				ld = clamp_duty(lt, cfg_q.floor, cfg_q.ceiling, 1'b0);
				rd = clamp_duty(rt, cfg_q.floor, cfg_q.ceiling, 1'b0);
			end
			MODE_SEARCH: begin
				ld = clamp_duty(14'sd560, cfg_q.floor, cfg_q.ceiling, 1'b1);
				rd = clamp_duty(14'sd533, cfg_q.floor, cfg_q.ceiling, 1'b1);
			end
			MODE_SHARP: begin
				corr = lim14(drsp.quotient, 14'sd380);
				ld = clamp_duty($signed({3'b000, cfg_q.left_base}) - corr,
					cfg_q.floor, cfg_q.ceiling, 1'b0);
				rd = clamp_duty($signed({3'b000, cfg_q.right_base}) + corr,
					cfg_q.floor, cfg_q.ceiling, 1'b0);
			end
			MODE_SETTLE: begin
				corr = lim14(drsp.quotient, 14'sd120);
				ld = clamp_duty(14'sd560 - corr, cfg_q.floor, cfg_q.ceiling, 1'b1);
				rd = clamp_duty(14'sd533 + corr, cfg_q.floor, cfg_q.ceiling, 1'b1);
			end
			default: begin
				tgt = lim14(drsp.quotient, 14'sd150);
				if (cdamp) tgt = '0;
				else if (zone && flip) begin
					// third of the magnitude by reciprocal, truncating toward zero
					tmag = tgt[13] ? 8'(-tgt) : 8'(tgt);
					tprod = 16'(tmag) * 16'd171;
					tgt = tgt[13] ? -14'(tprod[15:9]) : 14'(tprod[15:9]);
				end
				if (zone && (cdamp || flip)) begin
					if (14'(damp_q) < tgt)
						damp_n = (14'(damp_q) + 14'sd20 > tgt) ? 9'(tgt) : damp_q + 9'sd20;
					else if (14'(damp_q) > tgt)
						damp_n = (14'(damp_q) - 14'sd20 < tgt) ? 9'(tgt) : damp_q - 9'sd20;
					else damp_n = 9'(tgt);
				end else damp_n = 9'(tgt);
				corr = 14'(damp_n);
				ld = clamp_duty($signed({3'b000, cfg_q.left_base}) - corr,
					cfg_q.floor, cfg_q.ceiling, 1'b1);
				rd = clamp_duty($signed({3'b000, cfg_q.right_base}) + corr,
					cfg_q.floor, cfg_q.ceiling, 1'b1);
			end
		endcase
	end

	logic start_q;
	div_req_t dreq_mux;
	always_comb begin
		dreq_mux = dreq;
		if (start_q) begin
			dreq_mux.start = 1'b1;
			dreq_mux.dividend = sum;
			dreq_mux.divisor = {2'b00, (cnt == 3'd0) ? 3'd1 : cnt};
		end
	end

	lfmd_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (dreq_mux),
		.rsp    (drsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{11'd620, 11'd590, 11'd430, 11'd850, 12'd1800, 8'd18, 8'd28, 11'd260};
		end else if (cfg_we) begin
			case (reg_index_t'(cfg_index))
				REG_LEFT_BASE:  cfg_q.left_base <= cfg_data[10:0];
				REG_RIGHT_BASE: cfg_q.right_base <= cfg_data[10:0];
				REG_FLOOR:      cfg_q.floor <= cfg_data[10:0];
				REG_CEILING:    cfg_q.ceiling <= cfg_data[10:0];
				REG_SHARP_THR:  cfg_q.sharp_thr <= cfg_data;
				REG_COOLDOWN:   cfg_q.cooldown <= cfg_data[7:0];
				REG_SETTLE:     cfg_q.settle <= cfg_data[7:0];
				REG_LOST_FLOOR: cfg_q.lost_floor <= cfg_data[10:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			start_q <= 1'b0;
			held_q <= '0;
			lost_q <= '0;
			ever_q <= 1'b0;
			tsign_q <= '0;
			mode_q <= MODE_NORMAL;
			settle_q <= '0;
			crun_q <= '0;
			damp_q <= '0;
			prev_q <= '0;
			erun_q <= '0;
			brun_q <= '0;
			cool_q <= '0;
		end else begin
			state_q <= state_d;
			start_q <= state_q == ST_IDLE && in_valid;
			case (state_q)
				ST_DIV: if (drsp.done) begin
					if (seen) begin
						ever_q <= 1'b1;
						lost_q <= '0;
						held_q <= drsp.quotient[12:0];
						if (drsp.quotient >= 14'sd700) tsign_q <= 2'b01;
						else if (drsp.quotient <= -14'sd700) tsign_q <= 2'b11;
					end else if (lost_q != 16'hFFFF) lost_q <= lost_q + 16'd1;
				end
				ST_DECIDE: begin
					erun_q <= erun_n;
					brun_q <= brun_n;
					cool_q <= cool_n;
					mode_q <= mode_n;
					case (mode_n)
						MODE_LOST, MODE_SHARP: begin
							settle_q <= cfg_q.settle;
							crun_q <= '0;
							damp_q <= '0;
							prev_q <= '0;
						end
						MODE_SEARCH: begin
							damp_q <= '0;
							prev_q <= '0;
						end
						MODE_SETTLE: begin
							crun_q <= crun_n;
							damp_q <= '0;
							prev_q <= '0;
							settle_q <= (crun_n == 4'd8) ? 8'd0 : settle_q - 8'd1;
						end
						default: crun_q <= crun_n;
					endcase
				end
				ST_QUOT: if (drsp.done && mode_q == MODE_NORMAL) begin
					damp_q <= damp_n;
					prev_q <= err;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) mask_q <= sensor_mask;
		if (state_q == ST_QUOT && drsp.done) begin
			left_duty <= ld;
			right_duty <= rd;
			drive_mode <= mode_q;
			line_error <= held_q;
			line_seen <= seen;
			steer_correction <= corr[9:0];
		end
	end

	assign in_stall = state_q != ST_IDLE;
	assign out_valid = state_q == ST_FINISH;

	assert property (@(posedge clk) disable iff (!arst_n) out_valid |-> in_stall)
		else $error("item accepted while result pending");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DECIDE) |=> state_q == ST_QUOT)
		else $error("sequencer skipped quotient step");
	assert property (@(posedge clk) disable iff (!arst_n) crun_q <= 4'd8)
		else $error("centre run overflow");

endmodule

// ----- hw/rtl/lfmd_div.sv -----
// shared restoring divider, signed dividend by small unsigned divisor, truncating
module lfmd_div
	import lfmd_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic [3:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic        neg_q;
	logic [13:0] rem_q;
	logic [13:0] quo_q;
	logic [4:0]  dsr_q;
	logic [14:0] trial;

	assign trial = {rem_q, quo_q[13]} - {10'd0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 4'd1;
				if (cnt_q == 4'd13) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			neg_q <= req.dividend[13];
			quo_q <= req.dividend[13] ? 14'(-req.dividend) : req.dividend;
			rem_q <= '0;
			dsr_q <= req.divisor;
		end else if (busy_q) begin
			if (!trial[14]) begin
				rem_q <= trial[13:0];
				quo_q <= {quo_q[12:0], 1'b1};
			end else begin
				rem_q <= {rem_q[12:0], quo_q[13]};
				quo_q <= {quo_q[12:0], 1'b0};
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.quotient = neg_q ? -$signed(quo_q) : $signed(quo_q);

	assert property (@(posedge clk) disable iff (!arst_n) rsp.done |-> !busy_q)
		else $error("divider done while busy");
	assert property (@(posedge clk) disable iff (!arst_n) req.start |=> busy_q)
		else $error("divider did not start");
	assert property (@(posedge clk) disable iff (!arst_n) busy_q |-> dsr_q != 5'd0)
		else $error("divider zero divisor");

endmodule
